@@ src/fbsdp_pkg.sv @@
`default_nettype none

package fbsdp_pkg;

    localparam int GROUP_ELEMS = 16;
    localparam int DOT_W       = 17;

    localparam logic [2:0]  E2M1_MAG_MASK  = 3'h7;
    localparam logic [7:0]  EXP_ALL_ONES   = 8'hFF;
    localparam logic [31:0] FP32_QNAN_BIT  = 32'h0040_0000;
    localparam logic [31:0] FP32_DFLT_NAN  = 32'hFFC0_0000;
    localparam logic [30:0] FP32_INF_MAG   = 31'h7F80_0000;
    localparam logic [15:0] BF16_QNAN_BIT  = 16'h0040;
    localparam logic [31:0] BF16_RND_BIAS  = 32'h0000_7FFF;
    localparam logic        REG_MODE_INDEX = 1'b0;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [15:0]             group_scale;
        logic [15:0]             channel_scale;
        logic [31:0]             row_scale;
        logic                    last_group;
    } fbsdp_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PMUL,
        ST_ACC,
        ST_FIN_A,
        ST_FIN_B,
        ST_FIN_C,
        ST_ROUND
    } fbsdp_state_t;

    function automatic logic signed [5:0] e2m1_decode(input logic [3:0] code);
        logic [4:0] mag;
        case (code[2:0] & E2M1_MAG_MASK)
            3'd0:    mag = 5'd0;
            3'd1:    mag = 5'd1;
            3'd2:    mag = 5'd2;
            3'd3:    mag = 5'd3;
            3'd4:    mag = 5'd4;
            3'd5:    mag = 5'd6;
            3'd6:    mag = 5'd8;
            default: mag = 5'd12;
        endcase
        return code[3] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    function automatic logic is_nan(input logic [31:0] x);
        return (x[30:23] == EXP_ALL_ONES) && (x[22:0] != 23'd0);
    endfunction

    // value = p * 2^e, p non-zero; RNE to fp32 incl. subnormals
    function automatic logic [31:0] round_pack(input logic s, input logic [63:0] p,
                                               input int e);
        int          k;
        int          u;
        int          sh;
        int          bexp;
        logic [63:0] m;
        logic        guard;
        logic        sticky;
        k = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (p[i])
            begin
                k = i;
            end
        end
        u = k + e - 23;
        if (u < -149)
        begin
            u = -149;
        end
        sh = u - e;
        if (sh <= 0)
        begin
            m      = p << (-sh);
            guard  = 1'b0;
            sticky = 1'b0;
        end
        else if (sh > 64)
        begin
            m      = 64'd0;
            guard  = 1'b0;
            sticky = |p;
        end
        else
        begin
            m      = (sh == 64) ? 64'd0 : (p >> sh);
            guard  = p[sh-1];
            sticky = |(p & ((64'd1 << (sh - 1)) - 64'd1));
        end
        if (guard && (sticky || m[0]))
        begin
            m = m + 64'd1;
        end
        if (m[24])
        begin
            m = m >> 1;
            u = u + 1;
        end
        if (m[23])
        begin
            bexp = u + 150;
            if (bexp >= 255)
            begin
                return {s, EXP_ALL_ONES, 23'd0};
            end
            return {s, bexp[7:0], m[22:0]};
        end
        return {s, 8'd0, m[22:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic        a_inf;
        logic        b_inf;
        logic        a_zero;
        logic        b_zero;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [47:0] prod;
        int          ea;
        int          eb;
        s      = a[31] ^ b[31];
        a_inf  = a[30:0] == FP32_INF_MAG;
        b_inf  = b[30:0] == FP32_INF_MAG;
        a_zero = a[30:0] == 31'd0;
        b_zero = b[30:0] == 31'd0;
        ma     = {|a[30:23], a[22:0]};
        mb     = {|b[30:23], b[22:0]};
        ea     = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
        eb     = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
        prod   = ma * mb;
        if (is_nan(a))
        begin
            return a | FP32_QNAN_BIT;
        end
        if (is_nan(b))
        begin
            return b | FP32_QNAN_BIT;
        end
        if ((a_inf && b_zero) || (b_inf && a_zero))
        begin
            return FP32_DFLT_NAN;
        end
        if (a_inf || b_inf)
        begin
            return {s, FP32_INF_MAG};
        end
        if (a_zero || b_zero)
        begin
            return {s, 31'd0};
        end
        return round_pack(s, {16'd0, prod}, ea + eb - 300);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x;
        logic [31:0] y;
        logic [63:0] big;
        logic [63:0] sml;
        logic [63:0] full;
        logic [63:0] sum;
        logic        s;
        int          ex;
        int          ey;
        int          d;
        if (is_nan(a))
        begin
            return a | FP32_QNAN_BIT;
        end
        if (is_nan(b))
        begin
            return b | FP32_QNAN_BIT;
        end
        if ((a[30:0] == FP32_INF_MAG) && (b[30:0] == FP32_INF_MAG) && (a[31] != b[31]))
        begin
            return FP32_DFLT_NAN;
        end
        if (a[30:0] == FP32_INF_MAG)
        begin
            return a;
        end
        if (b[30:0] == FP32_INF_MAG)
        begin
            return b;
        end
        if (a[30:23] >= b[30:23])
        begin
            x = a;
            y = b;
        end
        else
        begin
            x = b;
            y = a;
        end
        ex   = (x[30:23] == 8'd0) ? 1 : int'(x[30:23]);
        ey   = (y[30:23] == 8'd0) ? 1 : int'(y[30:23]);
        d    = ex - ey;
        big  = {14'd0, |x[30:23], x[22:0], 26'd0};
        full = {14'd0, |y[30:23], y[22:0], 26'd0};
        if (d >= 50)
        begin
            sml = {63'd0, |full};
        end
        else
        begin
            sml = (full >> d) | {63'd0, |(full & ((64'd1 << d) - 64'd1))};
        end
        if (x[31] == y[31])
        begin
            sum = big + sml;
            s   = x[31];
        end
        else if (big >= sml)
        begin
            sum = big - sml;
            s   = x[31];
        end
        else
        begin
            sum = sml - big;
            s   = y[31];
        end
        if (sum == 64'd0)
        begin
            return {x[31] & y[31], 31'd0};
        end
        return round_pack(s, sum, ex - 176);
    endfunction

    function automatic logic [31:0] int_to_fp(input logic [31:0] v);
        logic [32:0] mag;
        mag = v[31] ? (~{1'b1, v} + 33'd1) : {1'b0, v};
        if (v == 32'd0)
        begin
            return 32'd0;
        end
        return round_pack(v[31], {31'd0, mag}, 0);
    endfunction

    function automatic logic [15:0] to_bf16(input logic [31:0] u);
        logic [31:0] r;
        r = u + BF16_RND_BIAS + {31'd0, u[16]};
        if (is_nan(u))
        begin
            return u[31:16] | BF16_QNAN_BIT;
        end
        return r[31:16];
    endfunction

endpackage

`default_nettype wire

@@ src/fbsdp_if.sv @@
`default_nettype none

interface fbsdp_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] act_low;
    logic [63:0] act_high;
    logic [63:0] weight_nibbles;
    logic [15:0] group_scale;
    logic [15:0] channel_scale;
    logic [31:0] row_scale;
    logic        last_group;

    modport source (output valid, act_low, act_high, weight_nibbles, group_scale,
                    channel_scale, row_scale, last_group, input ready);
    modport sink (input valid, act_low, act_high, weight_nibbles, group_scale,
                  channel_scale, row_scale, last_group, output ready);
endinterface

interface fbsdp_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_bf16;

    modport source (output valid, result_bf16, input ready);
    modport sink (input valid, result_bf16, output ready);
endinterface

`default_nettype wire

@@ src/fbsdp_front.sv @@
`default_nettype none

module fbsdp_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    fbsdp_in_if.sink                in_ch,
    output fbsdp_pkg::fbsdp_job_t   job,
    output logic                    job_valid,
    input  wire logic               job_ready
);
    import fbsdp_pkg::*;

    logic                    valid_reg;
    logic                    valid_next;
    fbsdp_job_t              job_reg;
    logic signed [DOT_W-1:0] dot;
    logic                    take;

    // one lane per element, 8b x 6b products
    always_comb
    begin
        logic [127:0] acts;
        dot  = '0;
        acts = {in_ch.act_high, in_ch.act_low};
        for (int i = 0; i < GROUP_ELEMS; i++)
        begin
            dot = dot + DOT_W'($signed(acts[8*i +: 8]) *
                               e2m1_decode(in_ch.weight_nibbles[4*i +: 4]));
        end
    end

    assign in_ch.ready = !valid_reg || job_ready;
    assign take        = in_ch.valid && in_ch.ready;
    assign valid_next  = take || (valid_reg && !job_ready);
    assign job         = job_reg;
    assign job_valid   = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg <= '{dot: dot, group_scale: in_ch.group_scale,
                         channel_scale: in_ch.channel_scale,
                         row_scale: in_ch.row_scale, last_group: in_ch.last_group};
        end
    end

endmodule

`default_nettype wire

@@ src/fbsdp_fifo.sv @@
`default_nettype none

module fbsdp_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire fbsdp_pkg::fbsdp_job_t wr_job,
    input  wire logic               wr_valid,
    output logic                    wr_ready,
    output fbsdp_pkg::fbsdp_job_t   rd_job,
    output logic                    rd_valid,
    input  wire logic               rd_ready
);
    import fbsdp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fbsdp_job_t      mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            push;
    logic            pop;

    assign wr_ready = count_reg != CW'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_job   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

@@ src/fbsdp_back.sv @@
`default_nettype none

module fbsdp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               block_scaled_mode,
    input  wire fbsdp_pkg::fbsdp_job_t job,
    input  wire logic               job_valid,
    output logic                    job_ready,
    fbsdp_out_if.source             out_ch
);
    import fbsdp_pkg::*;

    fbsdp_state_t state_reg;
    fbsdp_state_t state_next;
    fbsdp_job_t   job_reg;
    logic [31:0]  tmp_reg;
    logic [31:0]  tmp_next;
    logic [31:0]  fsum_reg;
    logic [31:0]  fsum_next;
    logic [31:0]  isum_reg;
    logic [31:0]  isum_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [15:0]  result_reg;
    logic         slot_free;

    assign slot_free = !out_valid_reg || out_ch.ready;
    assign job_ready = state_reg == ST_IDLE;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  state_next = job_valid ? ST_CONV : ST_IDLE;
            ST_CONV:  state_next = ST_PMUL;
            ST_PMUL:  state_next = ST_ACC;
            ST_ACC:   state_next = job_reg.last_group ? ST_FIN_A : ST_IDLE;
            ST_FIN_A: state_next = block_scaled_mode ? ST_ROUND : ST_FIN_B;
            ST_FIN_B: state_next = ST_FIN_C;
            ST_FIN_C: state_next = ST_ROUND;
            ST_ROUND: state_next = slot_free ? ST_IDLE : ST_ROUND;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        tmp_next       = tmp_reg;
        fsum_next      = fsum_reg;
        isum_next      = isum_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        unique case (state_reg)
            ST_CONV:  tmp_next = int_to_fp(32'(job_reg.dot));
            ST_PMUL:  tmp_next = fp_mul(tmp_reg, {job_reg.group_scale, 16'd0});
            ST_ACC:
            begin
                fsum_next = fp_add(fsum_reg, tmp_reg);
                isum_next = isum_reg + 32'(job_reg.dot);
            end
            ST_FIN_A: tmp_next = block_scaled_mode ? fp_mul(fsum_reg, job_reg.row_scale)
                                                   : int_to_fp(isum_reg);
            ST_FIN_B: tmp_next = fp_mul(tmp_reg, {job_reg.channel_scale, 16'd0});
            ST_FIN_C: tmp_next = fp_mul(tmp_reg, job_reg.row_scale);
            ST_ROUND:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    fsum_next      = 32'd0;
                    isum_next      = 32'd0;
                end
            end
            default:  tmp_next = tmp_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fsum_reg      <= 32'd0;
            isum_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fsum_reg      <= fsum_next;
            isum_reg      <= isum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tmp_reg <= tmp_next;
        if (state_reg == ST_IDLE && job_valid)
        begin
            job_reg <= job;
        end
        if (state_reg == ST_ROUND && slot_free)
        begin
            result_reg <= to_bf16(tmp_reg);
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.result_bf16 = result_reg;

endmodule

`default_nettype wire

@@ src/fp4_block_scaled_dot_product_unit.sv @@
`default_nettype none

// channel  | dir | handshake          | beat
// in_ch    | in  | valid/ready        | one 16-element K group
// out_ch   | out | valid/ready        | one bf16 result, last group only
// apb      | in  | psel/penable/pready| mode register, byte addresses 0-3
//
// The back end takes one queued group at a time and runs convert, multiply and
// accumulate through one fp32 datapath. A last group then adds the final scaling
// (block-scaled: FIN_A; per-channel: FIN_A, FIN_B, FIN_C) and rounding.
// Reset clears sums and queue and sets block-scaled mode. A stalled result holds in the
// output register while the front end and queue keep taking beats as long as the queue has room.

module fp4_block_scaled_dot_product_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    fbsdp_in_if.sink         in_ch,
    fbsdp_out_if.source      out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import fbsdp_pkg::*;

    logic       mode_reg;
    fbsdp_job_t f_job;
    logic       f_valid;
    logic       f_ready;
    fbsdp_job_t q_job;
    logic       q_valid;
    logic       q_ready;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODE_INDEX) ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_MODE_INDEX))
        begin
            mode_reg <= pwdata[0];
        end
    end

    fbsdp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .job       (f_job),
        .job_valid (f_valid),
        .job_ready (f_ready)
    );

    fbsdp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_job   (f_job),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .rd_job   (q_job),
        .rd_valid (q_valid),
        .rd_ready (q_ready)
    );

    fbsdp_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .block_scaled_mode (mode_reg),
        .job               (q_job),
        .job_valid         (q_valid),
        .job_ready         (q_ready),
        .out_ch            (out_ch)
    );

endmodule

`default_nettype wire

@@ src/fbsdp_checker.sv @@
`default_nettype none

module fbsdp_sva (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] result_bf16,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_bf16))
        else $error("result beat dropped or changed while stalled");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    a_mode_wr: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && !paddr[2] |=> paddr[2] || prdata[0] == $past(pwdata[0]))
        else $error("mode register readback mismatch");

    a_rst_out: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind fp4_block_scaled_dot_product_unit fbsdp_sva u_fbsdp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .result_bf16 (out_ch.result_bf16),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
);

`default_nettype wire
